### hdl/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared constants and types of the binary min-heap engine.
// ----------------------------------------------------------------------------
`default_nettype none
package bmh_pkg;
   localparam int HEAP_DEPTH = 1024;
   localparam int ADDR_W  = $clog2(HEAP_DEPTH + 1);
   localparam int SLOT_W  = $clog2(HEAP_DEPTH);
   localparam int COUNT_W = 11;
   localparam int KEY_W   = 32;

   typedef enum logic [1:0] {
      MODE_INSERT   = 2'd0,
      MODE_DELETE   = 2'd1,
      MODE_DECREASE = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_POS = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic signed [31:0]  value;
      logic [10:0]         position;
      logic [30:0]         amount;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [31:0]  removed_value;
      logic signed [31:0]  minimum;
      logic [10:0]         count;
   } rsp_type;
endpackage
`default_nettype wire

### hdl/bmh_if.sv
// ----------------------------------------------------------------------------
// bmh_req_if / bmh_rsp_if
// Valid/ready channels of the heap engine.
// ----------------------------------------------------------------------------
`default_nettype none
interface bmh_req_if import bmh_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bmh_rsp_if import bmh_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/bmh_ram.sv
// ----------------------------------------------------------------------------
// bmh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  addr,
   input  wire [WIDTH-1:0]          wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

### hdl/binary_min_heap_engine.sv
// ----------------------------------------------------------------------------
// binary_min_heap_engine
// One-indexed binary min-heap of signed 32-bit keys in a single-port RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one word per operation: insert, delete at position, or
//   decrease at position. rsp_ returns one word per request: status, the
//   removed key, the new minimum and the count.
//   One request is worked at a time. The key store is a single-port RAM with
//   registered read; every access (read or write) holds the port, and the
//   sequencer is bound by that port. Each sift level going up reads the
//   parent, then compares and writes; going down it reads the left child,
//   reads the right child, then compares and writes. The next request can
//   be taken in the cycle after the response is loaded.
//   The current root is kept in a register, so the minimum costs no read.
//   Reset clears the count, the control state and the response valid; the
//   RAM is not cleared, since no key outside slots 1..count is ever used.
//   The response sits in an output register; while the receiver stalls, the
//   engine still takes and works one more request, then holds it in the
//   finish state until the waiting word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module binary_min_heap_engine import bmh_pkg::*; (
   input wire          clock,
   input wire          reset,
   bmh_req_if.sink     req,
   bmh_rsp_if.source   rsp
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_RDPOS = 11'b00000000010,
      S_RDLST = 11'b00000000100,
      S_FILL  = 11'b00000001000,
      S_UPRD  = 11'b00000010000,
      S_UPCMP = 11'b00000100000,
      S_DNRL  = 11'b00001000000,
      S_DNRR  = 11'b00010000000,
      S_DNCMP = 11'b00100000000,
      S_FIN   = 11'b01000000000,
      S_DECR  = 11'b10000000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                mode_ff, mode_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]         slot_ff, slot_in;      // current hole
   logic signed [KEY_W-1:0]   key_ff, key_in;        // key being sifted
   logic signed [KEY_W-1:0]   left_ff, left_in;      // left child key
   logic signed [KEY_W-1:0]   root_ff, root_in;
   logic [30:0]               amount_ff, amount_in;
   logic                      up_ff, up_in;          // sift direction for FILL
   status_type                status_ff, status_in;
   logic signed [KEY_W-1:0]   removed_ff, removed_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         addr;
   logic signed [KEY_W-1:0]   wr_data, rd_data;
   logic signed [KEY_W:0]     diff;
   logic [ADDR_W-1:0]         parent, kid;

   bmh_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr[SLOT_W-1:0] - SLOT_W'(1)),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign parent      = slot_ff >> 1;
   assign kid         = {slot_ff[ADDR_W-2:0], 1'b0};
   assign diff        = {rd_data[KEY_W-1], rd_data} - {1'b0, 1'b0, amount_ff};

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      key_in       = key_ff;
      left_in      = left_ff;
      root_in      = root_ff;
      amount_in    = amount_ff;
      up_in        = up_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      rsp_in       = rsp_ff;
      // drop the held word once the receiver takes it
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      wr_en        = 1'b0;
      addr         = slot_ff;
      wr_data      = key_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               mode_in         = req.payload.mode;
               amount_in       = req.payload.amount;
               status_in       = ST_DONE;
               removed_in      = '0;
               slot_in         = ADDR_W'(req.payload.position);
               state_in        = S_FIN;
               case (req.payload.mode)
                  MODE_INSERT: begin
                     if (count_ff >= COUNT_W'(HEAP_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        slot_in  = ADDR_W'(count_ff + 1'b1);
                        key_in   = req.payload.value;
                        state_in = S_UPRD;
                     end
                  end
                  MODE_DELETE, MODE_DECREASE: begin
                     if (req.payload.position == '0 || req.payload.position > count_ff) begin
                        status_in = ST_BAD_POS;
                     end else begin
                        state_in = S_RDPOS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RDPOS: begin
            // read issued at slot; data next cycle
            state_in = (mode_ff == MODE_DELETE) ? S_RDLST : S_DECR;
         end
         S_DECR: begin
            if (diff < -(KEY_W+1)'(64'sh80000000)) key_in = {1'b1, {(KEY_W-1){1'b0}}};
            else key_in = diff[KEY_W-1:0];
            state_in = S_UPRD;
         end
         S_RDLST: begin
            removed_in = rd_data;
            addr     = ADDR_W'(count_ff);
            count_in = count_ff - 1'b1;
            state_in = S_FILL;
         end
         S_FILL: begin
            // rd_data holds the last key; decide direction by the parent
            key_in = rd_data;
            if (slot_ff > ADDR_W'(count_ff)) begin
               state_in = S_FIN;            // deleted the last slot
            end else if (slot_ff > ADDR_W'(1)) begin
               addr     = parent;
               up_in    = 1'b1;
               state_in = S_UPCMP;
            end else begin
               up_in    = 1'b0;
               state_in = S_DNRL;
            end
         end
         S_UPRD: begin
            if (slot_ff > ADDR_W'(1)) begin
               addr     = parent;
               up_in    = 1'b0;
               state_in = S_UPCMP;
            end else begin
               wr_en    = 1'b1;
               root_in  = key_ff;
               state_in = S_FIN;
            end
         end
         S_UPCMP: begin
            if (rd_data > key_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               if (slot_ff == ADDR_W'(1)) root_in = rd_data;
               slot_in  = parent;
               up_in    = 1'b0;
               state_in = S_UPRD;
            end else if (up_ff) begin
               state_in = S_DNRL;           // refilled hole not below parent
            end else begin
               wr_en    = 1'b1;
               if (slot_ff == ADDR_W'(1)) root_in = key_ff;
               state_in = S_FIN;
            end
         end
         S_DNRL: begin
            if (kid > ADDR_W'(count_ff) || kid < slot_ff) begin
               wr_en    = 1'b1;
               if (slot_ff == ADDR_W'(1)) root_in = key_ff;
               state_in = S_FIN;
            end else begin
               addr     = kid;
               state_in = S_DNRR;
            end
         end
         S_DNRR: begin
            left_in = rd_data;
            addr    = kid + 1'b1;
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (kid + 1'b1 <= ADDR_W'(count_ff) && rd_data < left_ff) begin
               if (rd_data < key_ff) begin
                  wr_en   = 1'b1;
                  wr_data = rd_data;
                  if (slot_ff == ADDR_W'(1)) root_in = rd_data;
                  slot_in = kid + 1'b1;
                  state_in = S_DNRL;
               end else begin
                  wr_en   = 1'b1;
                  if (slot_ff == ADDR_W'(1)) root_in = key_ff;
                  state_in = S_FIN;
               end
            end else if (left_ff < key_ff) begin
               wr_en   = 1'b1;
               wr_data = left_ff;
               if (slot_ff == ADDR_W'(1)) root_in = left_ff;
               slot_in = kid;
               state_in = S_DNRL;
            end else begin
               wr_en   = 1'b1;
               if (slot_ff == ADDR_W'(1)) root_in = key_ff;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // load the output register once it is free or being taken
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_in.status        = status_ff;
               rsp_in.removed_value = removed_ff;
               rsp_in.count         = count_ff;
               rsp_in.minimum       = (count_ff == '0) ? '0 : root_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff    <= mode_in;
      slot_ff    <= slot_in;
      key_ff     <= key_in;
      left_ff    <= left_in;
      root_ff    <= root_in;
      amount_ff  <= amount_in;
      up_ff      <= up_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
   end
endmodule
`default_nettype wire

### test/binary_min_heap_engine_checker.sv
// ----------------------------------------------------------------------------
// binary_min_heap_engine_checker
// Watches the request and response channels of the heap engine, keeps its own
// heap, predicts one response word per accepted request and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module binary_min_heap_engine_checker import bmh_pkg::*; (
   input wire   clock,
   input wire   reset,
   bmh_req_if   req,
   bmh_rsp_if   rsp,
   output int   fail_count,
   output int   pending_count
);
   logic signed [31:0] heap_keys [1:HEAP_DEPTH];
   int unsigned        heap_size;
   rsp_type            rsp_queue [$];

   assign pending_count = rsp_queue.size();

   function automatic void raise_key(int unsigned slot);
      logic signed [31:0] key;
      key = heap_keys[slot];
      while (slot > 1 && heap_keys[slot / 2] > key) begin
         heap_keys[slot] = heap_keys[slot / 2];
         slot = slot / 2;
      end
      heap_keys[slot] = key;
   endfunction

   function automatic void lower_key(int unsigned slot);
      logic signed [31:0] key;
      int unsigned        kid;
      key = heap_keys[slot];
      forever begin
         kid = slot * 2;
         if (kid > heap_size) break;
         if (kid + 1 <= heap_size && heap_keys[kid + 1] < heap_keys[kid]) kid++;
         if (!(heap_keys[kid] < key)) break;
         heap_keys[slot] = heap_keys[kid];
         slot = kid;
      end
      heap_keys[slot] = key;
   endfunction

   function automatic rsp_type apply_heap_op(req_type op);
      rsp_type     res;
      int unsigned pos;
      longint      lowered;
      res = '0;
      pos = op.position;
      case (op.mode)
         MODE_INSERT: begin
            if (heap_size >= HEAP_DEPTH) res.status = ST_FULL;
            else begin
               heap_size++;
               heap_keys[heap_size] = op.value;
               raise_key(heap_size);
            end
         end
         MODE_DELETE, MODE_DECREASE: begin
            if (pos == 0 || pos > heap_size) res.status = ST_BAD_POS;
            else if (op.mode == MODE_DELETE) begin
               res.removed_value = heap_keys[pos];
               heap_keys[pos] = heap_keys[heap_size];
               heap_size--;
               if (pos <= heap_size) begin
                  if (pos > 1 && heap_keys[pos / 2] > heap_keys[pos]) raise_key(pos);
                  else lower_key(pos);
               end
            end else begin
               lowered = longint'(heap_keys[pos]) - longint'(op.amount);
               if (lowered < -64'sd2147483648) lowered = -64'sd2147483648;
               heap_keys[pos] = lowered[31:0];
               raise_key(pos);
            end
         end
         default: ;
      endcase
      res.minimum = heap_size > 0 ? heap_keys[1] : '0;
      res.count   = heap_size[10:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type seen, want;
      int      errs;
      errs = 0;
      if (reset) begin
         heap_size = 0;
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) rsp_queue.push_back(apply_heap_op(req.payload));
         if (rsp.valid && rsp.ready) begin
            seen = rsp.payload;
            if (rsp_queue.size() == 0) begin
               $error("response word with nothing expected");
               errs++;
            end else begin
               want = rsp_queue.pop_front();
               if (seen.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, seen.status);
                  errs++;
               end
               if (seen.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         want.removed_value, seen.removed_value);
                  errs++;
               end
               if (seen.minimum !== want.minimum) begin
                  $error("minimum: expected %0d, got %0d", want.minimum, seen.minimum);
                  errs++;
               end
               if (seen.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, seen.count);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

### test/binary_min_heap_engine_test.sv
// ----------------------------------------------------------------------------
// binary_min_heap_engine_test
// Drives directed and random heap operations through the engine, with idle
// and stall phases and one long receiver hold-off, and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module binary_min_heap_engine_test;
   import bmh_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   cycle_count = 0;

   // Idle percentages for sender and receiver; stall_hold forces a long stall.
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   stall_hold = 1'b0;
   // Our own count of keys, used to aim positions at live slots.
   int   live_count = 0;

   bmh_req_if req ();
   bmh_rsp_if rsp ();

   binary_min_heap_engine u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   binary_min_heap_engine_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req.valid   = 1'b0;
      req.payload = '0;
      rsp.ready   = 1'b0;
   end

   // Receiver: stall at the current rate, or hold off fully while asked.
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !stall_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: end the run if it takes far too long.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Track the live key count from accepted words, so positions stay useful.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         case (req.payload.mode)
            MODE_INSERT:
               if (live_count < HEAP_DEPTH) live_count <= live_count + 1;
            MODE_DELETE:
               if (req.payload.position != 0 && req.payload.position <= live_count)
                  live_count <= live_count - 1;
            default: ;
         endcase
      end
   end

   // Offer one word, with random idle cycles before it; hold until accepted.
   // Valid stays high after acceptance so back-to-back words need no gap.
   task automatic send_word(mode_type m, logic signed [31:0] v, int p, logic [30:0] a);
      req_type w;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      w.mode = m;
      w.value = v;
      w.position = p[10:0];
      w.amount = a;
      req.valid   <= 1'b1;
      req.payload <= w;
      do @(posedge clock); while (!req.ready);
   endtask

   function automatic logic signed [31:0] random_key();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed(32'($urandom_range(40))) - 20;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic [30:0] random_amount();
      case ($urandom_range(3))
         0: return 31'h7fff_ffff;
         1: return 31'($urandom_range(16));
         default: return 31'($urandom);
      endcase
   endfunction

   // Pick a position: mostly a live slot, sometimes 0, past the end or top.
   function automatic int random_position(int live);
      case ($urandom_range(9))
         0: return 0;
         1: return live + 1 + $urandom_range(3);
         2: return $urandom_range(2047);
         3: return live;
         default: return live > 0 ? $urandom_range(live, 1) : 1;
      endcase
   endfunction

   task automatic random_ops(int n, int grow_pct);
      int r;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < grow_pct)
            send_word(MODE_INSERT, random_key(), $urandom_range(2047), 31'($urandom));
         else if (r < grow_pct + (100 - grow_pct) / 2)
            send_word(MODE_DELETE, random_key(), random_position(live_count),
                      31'($urandom));
         else if (r < 98)
            send_word(MODE_DECREASE, random_key(), random_position(live_count),
                      random_amount());
         else
            send_word(MODE_NONE, random_key(), random_position(live_count),
                      31'($urandom));
      end
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-heap errors, extremes, equal keys, saturation, last slot.
      recv_stall_pct = 0;
      send_word(MODE_DELETE, 0, 1, 0);
      send_word(MODE_DECREASE, 0, 0, 0);
      send_word(MODE_NONE, 32'sh7fff_ffff, 2047, 31'h7fff_ffff);
      send_word(MODE_INSERT, 32'sh7fff_ffff, 0, 0);
      send_word(MODE_INSERT, 32'sh8000_0000, 0, 0);
      send_word(MODE_INSERT, 5, 0, 0);
      send_word(MODE_INSERT, 5, 0, 0);
      send_word(MODE_INSERT, 5, 0, 0);
      send_word(MODE_INSERT, -1, 0, 0);
      send_word(MODE_DECREASE, 0, 3, 31'h7fff_ffff);
      send_word(MODE_DECREASE, 0, 6, 0);
      send_word(MODE_DECREASE, 0, 7, 1);
      send_word(MODE_DELETE, 0, 6, 0);
      send_word(MODE_DELETE, 0, 2, 0);
      send_word(MODE_DELETE, 0, 1, 0);
      send_word(MODE_DELETE, 0, 0, 0);
      send_word(MODE_DELETE, 0, 2047, 0);
      send_word(MODE_DECREASE, 0, 1024, 5);
      send_word(MODE_NONE, 0, 1, 0);
      send_word(MODE_DELETE, 0, 1, 0);
      send_word(MODE_DELETE, 0, 1, 0);
      send_word(MODE_DELETE, 0, 1, 0);

      // Random phases: free-running, sender idle, receiver stall, both.
      random_ops(100, 60);
      send_idle_pct = 57;
      random_ops(100, 70);
      send_idle_pct = 0;
      recv_stall_pct = 57;
      random_ops(100, 70);
      send_idle_pct = 30;
      recv_stall_pct = 30;
      random_ops(100, 60);

      // Hold off the receiver while requests keep coming, so the input stalls.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            stall_hold = 1'b1;
            repeat (400) @(posedge clock);
            stall_hold = 1'b0;
         end
         random_ops(20, 70);
      join

      // Fill the store to the top, try to overfill, then shrink through it.
      while (live_count < HEAP_DEPTH)
         send_word(MODE_INSERT, random_key(), 0, 0);
      send_word(MODE_INSERT, 32'sh8000_0000, 0, 0);
      send_word(MODE_DELETE, 0, HEAP_DEPTH, 0);
      send_word(MODE_DECREASE, 0, HEAP_DEPTH - 1, random_amount());
      random_ops(50, 25);
      recv_stall_pct = 30;
      random_ops(50, 50);
      req.valid <= 1'b0;

      drain();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
